### rtl/core/sic_pkg.sv
// Shared types, codes and the step program of the Sampson inlier counter.
// Used by sampson_inlier_counter, sic_mac and sic_checker; depends on nothing else.
package sic_pkg;

    // running count and reported total
    localparam int COUNT_WIDTH = 16;
    localparam int TOTAL_WIDTH = 16;

    // APB-style register port
    localparam int PADDR_W = 6;
    localparam int PDATA_W = 64;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_F_ROW0_AB     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_F_ROW0C_ROW1A = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_F_ROW1_BC     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_F_ROW2_AB     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_F_ROW2_C      = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD     = 3'd5;

    localparam logic [31:0] THRESHOLD_RESET = 32'd262144;

    // signed accumulator; the final sum den*thr - num*2^16 needs about 140 bits
    localparam int ACC_W = 144;

    // constant 2^16 used for the homogeneous coordinate
    localparam logic signed [31:0] K16 = 32'sh0001_0000;

    // operand sources
    localparam int SRC_W = 5;
    localparam logic [SRC_W-1:0] SRC_F00 = 5'd0;
    localparam logic [SRC_W-1:0] SRC_F01 = 5'd1;
    localparam logic [SRC_W-1:0] SRC_F02 = 5'd2;
    localparam logic [SRC_W-1:0] SRC_F10 = 5'd3;
    localparam logic [SRC_W-1:0] SRC_F11 = 5'd4;
    localparam logic [SRC_W-1:0] SRC_F12 = 5'd5;
    localparam logic [SRC_W-1:0] SRC_F20 = 5'd6;
    localparam logic [SRC_W-1:0] SRC_F21 = 5'd7;
    localparam logic [SRC_W-1:0] SRC_F22 = 5'd8;
    localparam logic [SRC_W-1:0] SRC_X1  = 5'd9;
    localparam logic [SRC_W-1:0] SRC_Y1  = 5'd10;
    localparam logic [SRC_W-1:0] SRC_X2  = 5'd11;
    localparam logic [SRC_W-1:0] SRC_Y2  = 5'd12;
    localparam logic [SRC_W-1:0] SRC_K16 = 5'd13;
    localparam logic [SRC_W-1:0] SRC_A0L = 5'd14;
    localparam logic [SRC_W-1:0] SRC_A0H = 5'd15;
    localparam logic [SRC_W-1:0] SRC_A1L = 5'd16;
    localparam logic [SRC_W-1:0] SRC_A1H = 5'd17;
    localparam logic [SRC_W-1:0] SRC_A2L = 5'd18;
    localparam logic [SRC_W-1:0] SRC_A2H = 5'd19;
    localparam logic [SRC_W-1:0] SRC_B0L = 5'd20;
    localparam logic [SRC_W-1:0] SRC_B0H = 5'd21;
    localparam logic [SRC_W-1:0] SRC_B1L = 5'd22;
    localparam logic [SRC_W-1:0] SRC_B1H = 5'd23;
    localparam logic [SRC_W-1:0] SRC_RL  = 5'd24;
    localparam logic [SRC_W-1:0] SRC_RH  = 5'd25;
    localparam logic [SRC_W-1:0] SRC_DL  = 5'd26;
    localparam logic [SRC_W-1:0] SRC_DM  = 5'd27;
    localparam logic [SRC_W-1:0] SRC_DH  = 5'd28;
    localparam logic [SRC_W-1:0] SRC_THR = 5'd29;

    // product alignment
    localparam int SH_W = 3;
    localparam logic [SH_W-1:0] SH_0  = 3'd0;
    localparam logic [SH_W-1:0] SH_16 = 3'd1;
    localparam logic [SH_W-1:0] SH_32 = 3'd2;
    localparam logic [SH_W-1:0] SH_48 = 3'd3;
    localparam logic [SH_W-1:0] SH_64 = 3'd4;
    localparam logic [SH_W-1:0] SH_80 = 3'd5;

    // where a finished sum goes
    localparam int STO_W = 4;
    localparam logic [STO_W-1:0] STO_NONE = 4'd0;
    localparam logic [STO_W-1:0] STO_A0   = 4'd1;
    localparam logic [STO_W-1:0] STO_A1   = 4'd2;
    localparam logic [STO_W-1:0] STO_A2   = 4'd3;
    localparam logic [STO_W-1:0] STO_B0   = 4'd4;
    localparam logic [STO_W-1:0] STO_B1   = 4'd5;
    localparam logic [STO_W-1:0] STO_R    = 4'd6;
    localparam logic [STO_W-1:0] STO_DEN  = 4'd7;
    localparam logic [STO_W-1:0] STO_FLAG = 4'd8;

    localparam int NUM_STEPS = 44;
    localparam int STEP_W = $clog2(NUM_STEPS);

    typedef struct packed {
        logic [SRC_W-1:0] a_src;
        logic [SRC_W-1:0] b_src;
        logic             clr;
        logic             neg;
        logic [SH_W-1:0]  shift;
        logic [STO_W-1:0] store;
    } uop_t;

    // control traveling with a product through the MAC pipe
    typedef struct packed {
        logic             vld;
        logic             clr;
        logic             sub;
        logic [SH_W-1:0]  shift;
        logic [STO_W-1:0] store;
    } mac_ctrl_t;

    function automatic uop_t mk(input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                input logic clr, input logic neg,
                                input logic [SH_W-1:0] sh, input logic [STO_W-1:0] st);
        uop_t u;
        u.a_src = a;
        u.b_src = b;
        u.clr   = clr;
        u.neg   = neg;
        u.shift = sh;
        u.store = st;
        return u;
    endfunction

    // One partial product per step. A consumer step comes only after the sum it reads
    // has passed the MAC pipe and its result latch.
    function automatic uop_t uop_at(input logic [STEP_W-1:0] idx);
        uop_t u;
        u = '0;
        unique case (idx)
            // line terms a = F*x1, b = F^T*x2, each floor(sum / 2^19)
            STEP_W'(0):  u = mk(SRC_F00, SRC_X1,  1'b1, 1'b0, SH_0, STO_NONE);
            STEP_W'(1):  u = mk(SRC_F01, SRC_Y1,  1'b0, 1'b0, SH_0, STO_NONE);
            STEP_W'(2):  u = mk(SRC_F02, SRC_K16, 1'b0, 1'b0, SH_0, STO_A0);
            STEP_W'(3):  u = mk(SRC_F10, SRC_X1,  1'b1, 1'b0, SH_0, STO_NONE);
            STEP_W'(4):  u = mk(SRC_F11, SRC_Y1,  1'b0, 1'b0, SH_0, STO_NONE);
            STEP_W'(5):  u = mk(SRC_F12, SRC_K16, 1'b0, 1'b0, SH_0, STO_A1);
            STEP_W'(6):  u = mk(SRC_F20, SRC_X1,  1'b1, 1'b0, SH_0, STO_NONE);
            STEP_W'(7):  u = mk(SRC_F21, SRC_Y1,  1'b0, 1'b0, SH_0, STO_NONE);
            STEP_W'(8):  u = mk(SRC_F22, SRC_K16, 1'b0, 1'b0, SH_0, STO_A2);
            STEP_W'(9):  u = mk(SRC_F00, SRC_X2,  1'b1, 1'b0, SH_0, STO_NONE);
            STEP_W'(10): u = mk(SRC_F10, SRC_Y2,  1'b0, 1'b0, SH_0, STO_NONE);
            STEP_W'(11): u = mk(SRC_F20, SRC_K16, 1'b0, 1'b0, SH_0, STO_B0);
            STEP_W'(12): u = mk(SRC_F01, SRC_X2,  1'b1, 1'b0, SH_0, STO_NONE);
            STEP_W'(13): u = mk(SRC_F11, SRC_Y2,  1'b0, 1'b0, SH_0, STO_NONE);
            STEP_W'(14): u = mk(SRC_F21, SRC_K16, 1'b0, 1'b0, SH_0, STO_B1);
            // den = a0^2 + a1^2 + b0^2 + b1^2, two limbs each
            STEP_W'(15): u = mk(SRC_A0L, SRC_A0L, 1'b1, 1'b0, SH_0,  STO_NONE);
            STEP_W'(16): u = mk(SRC_A0L, SRC_A0H, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(17): u = mk(SRC_A0H, SRC_A0L, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(18): u = mk(SRC_A0H, SRC_A0H, 1'b0, 1'b0, SH_64, STO_NONE);
            STEP_W'(19): u = mk(SRC_A1L, SRC_A1L, 1'b0, 1'b0, SH_0,  STO_NONE);
            STEP_W'(20): u = mk(SRC_A1L, SRC_A1H, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(21): u = mk(SRC_A1H, SRC_A1L, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(22): u = mk(SRC_A1H, SRC_A1H, 1'b0, 1'b0, SH_64, STO_NONE);
            STEP_W'(23): u = mk(SRC_B0L, SRC_B0L, 1'b0, 1'b0, SH_0,  STO_NONE);
            STEP_W'(24): u = mk(SRC_B0L, SRC_B0H, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(25): u = mk(SRC_B0H, SRC_B0L, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(26): u = mk(SRC_B0H, SRC_B0H, 1'b0, 1'b0, SH_64, STO_NONE);
            STEP_W'(27): u = mk(SRC_B1L, SRC_B1L, 1'b0, 1'b0, SH_0,  STO_NONE);
            STEP_W'(28): u = mk(SRC_B1L, SRC_B1H, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(29): u = mk(SRC_B1H, SRC_B1L, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(30): u = mk(SRC_B1H, SRC_B1H, 1'b0, 1'b0, SH_64, STO_DEN);
            // residual r = floor((x2*a0 + y2*a1 + a2*2^16) / 2^16)
            STEP_W'(31): u = mk(SRC_X2,  SRC_A0L, 1'b1, 1'b0, SH_0,  STO_NONE);
            STEP_W'(32): u = mk(SRC_X2,  SRC_A0H, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(33): u = mk(SRC_Y2,  SRC_A1L, 1'b0, 1'b0, SH_0,  STO_NONE);
            STEP_W'(34): u = mk(SRC_Y2,  SRC_A1H, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(35): u = mk(SRC_A2L, SRC_K16, 1'b0, 1'b0, SH_0,  STO_NONE);
            STEP_W'(36): u = mk(SRC_A2H, SRC_K16, 1'b0, 1'b0, SH_32, STO_R);
            // margin = den*thr - r^2 * 2^16; inlier when strictly positive
            STEP_W'(37): u = mk(SRC_DL,  SRC_THR, 1'b1, 1'b0, SH_0,  STO_NONE);
            STEP_W'(38): u = mk(SRC_DM,  SRC_THR, 1'b0, 1'b0, SH_32, STO_NONE);
            STEP_W'(39): u = mk(SRC_DH,  SRC_THR, 1'b0, 1'b0, SH_64, STO_NONE);
            STEP_W'(40): u = mk(SRC_RL,  SRC_RL,  1'b0, 1'b1, SH_16, STO_NONE);
            STEP_W'(41): u = mk(SRC_RL,  SRC_RH,  1'b0, 1'b1, SH_48, STO_NONE);
            STEP_W'(42): u = mk(SRC_RH,  SRC_RL,  1'b0, 1'b1, SH_48, STO_NONE);
            STEP_W'(43): u = mk(SRC_RH,  SRC_RH,  1'b0, 1'b1, SH_80, STO_FLAG);
            default:     u = '0;
        endcase
        return u;
    endfunction

endpackage

### rtl/core/sic_mac.sv
// Shared 32x32 multiply and shift-accumulate pipe of the Sampson inlier counter.
// Depends on sic_pkg (control struct, shift and store codes, accumulator width).
module sic_mac (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sic_pkg::mac_ctrl_t             req,
    input  logic [31:0]                    a_mag,
    input  logic [31:0]                    b_mag,
    output logic signed [sic_pkg::ACC_W-1:0] acc,
    output logic [sic_pkg::STO_W-1:0]      done_store
);

    sic_pkg::mac_ctrl_t s1_ctrl_reg;
    sic_pkg::mac_ctrl_t s2_ctrl_reg;
    logic [31:0] op_a_reg;
    logic [31:0] op_b_reg;
    logic [63:0] prod_reg;
    logic signed [sic_pkg::ACC_W-1:0] acc_reg;
    logic signed [sic_pkg::ACC_W-1:0] acc_next;
    logic signed [sic_pkg::ACC_W-1:0] aligned;
    logic signed [sic_pkg::ACC_W-1:0] acc_base;
    logic [sic_pkg::STO_W-1:0] s3_store_reg;

    // stage 1: operand registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_store_reg <= sic_pkg::STO_NONE;
        end
        else
        begin
            s1_ctrl_reg <= req;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_store_reg <= s2_ctrl_reg.vld ? s2_ctrl_reg.store : sic_pkg::STO_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg <= a_mag;
        op_b_reg <= b_mag;
        prod_reg <= op_a_reg * op_b_reg;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        aligned = '0;
        unique case (s2_ctrl_reg.shift)
            sic_pkg::SH_0:  aligned = $signed(sic_pkg::ACC_W'(prod_reg));
            sic_pkg::SH_16: aligned = $signed(sic_pkg::ACC_W'(prod_reg) << 16);
            sic_pkg::SH_32: aligned = $signed(sic_pkg::ACC_W'(prod_reg) << 32);
            sic_pkg::SH_48: aligned = $signed(sic_pkg::ACC_W'(prod_reg) << 48);
            sic_pkg::SH_64: aligned = $signed(sic_pkg::ACC_W'(prod_reg) << 64);
            sic_pkg::SH_80: aligned = $signed(sic_pkg::ACC_W'(prod_reg) << 80);
            default:        aligned = '0;
        endcase
        acc_base = s2_ctrl_reg.clr ? '0 : acc_reg;
        if (!s2_ctrl_reg.vld)
            acc_next = acc_reg;
        else if (s2_ctrl_reg.sub)
            acc_next = acc_base - aligned;
        else
            acc_next = acc_base + aligned;
    end

    assign acc = acc_reg;
    assign done_store = s3_store_reg;

endmodule

### rtl/core/sampson_inlier_counter.sv
// Top level of the Sampson-distance inlier counter: register port, sequencer,
// operand selection, result latches and running count. Depends on sic_pkg, sic_mac.
//
// One point correspondence per transaction is tested against the 3x3
// fundamental matrix held in the registers, without a divider: the point is
// an inlier when r^2 * 2^16 < error_threshold * den, where r is the epipolar
// residual and den the sum of squared line coefficients; a zero denominator or
// a zero threshold never gives an inlier. All arithmetic is exact fixed point
// in a 144-bit signed accumulator. A 44-step program feeds one shared
// 32x32 multiplier, one partial product per cycle, followed by the operand,
// product and accumulator registers of the multiply/accumulate pipeline and
// the posting of the result.
// in_ready is low while a transaction is in work. The result sits in an output
// register, so a new transaction is taken while the previous result still waits
// for out_ready; a finished result waits only if its predecessor is still held.
// The running count saturates at all ones; start_of_set clears it before the
// point that carries it is counted. Registers sit at byte addresses 8*i,
// 64 bits wide; write them only while no transaction is in work.
module sampson_inlier_counter (
    input  logic                               clk,
    input  logic                               rst_n,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sic_pkg::PADDR_W-1:0]        paddr,
    input  logic [sic_pkg::PDATA_W-1:0]        pwdata,
    output logic [sic_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [31:0]                 first_x,
    input  logic signed [31:0]                 first_y,
    input  logic signed [31:0]                 second_x,
    input  logic signed [31:0]                 second_y,
    input  logic                               start_of_set,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               is_inlier,
    output logic [sic_pkg::TOTAL_WIDTH-1:0]    inlier_total
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    // indexes of the line-term / residual latches
    localparam int LIN_A0 = 0;
    localparam int LIN_A1 = 1;
    localparam int LIN_A2 = 2;
    localparam int LIN_B0 = 3;
    localparam int LIN_B1 = 4;
    localparam int LIN_R  = 5;

    localparam logic [sic_pkg::COUNT_WIDTH-1:0] CNT_MAX = '1;

    // configuration
    logic [63:0]        f_row0_ab_reg;
    logic [63:0]        f_row0c_row1a_reg;
    logic [63:0]        f_row1_bc_reg;
    logic [63:0]        f_row2_ab_reg;
    logic signed [31:0] f_row2_c_reg;
    logic [31:0]        thr_reg;

    logic                          cfg_wr;
    logic [sic_pkg::REG_IDX_W-1:0] cfg_idx;

    // transaction in work
    logic signed [31:0] x1_reg;
    logic signed [31:0] y1_reg;
    logic signed [31:0] x2_reg;
    logic signed [31:0] y2_reg;
    logic               start_reg;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [sic_pkg::STEP_W-1:0]  step_reg;
    logic [sic_pkg::STEP_W-1:0]  step_next;

    // intermediate results, sign and magnitude
    logic        lin_sgn_reg [0:5];
    logic [63:0] lin_mag_reg [0:5];
    logic [95:0] den_reg;
    logic        hit_reg;

    logic [sic_pkg::COUNT_WIDTH-1:0] count_reg;
    logic [sic_pkg::COUNT_WIDTH-1:0] count_base;
    logic [sic_pkg::COUNT_WIDTH-1:0] count_next;

    logic                            out_valid_reg;
    logic                            out_inlier_reg;
    logic [sic_pkg::TOTAL_WIDTH-1:0] out_total_reg;

    logic in_fire;
    logic out_load;
    logic acc_pos;

    sic_pkg::uop_t       uop;
    sic_pkg::mac_ctrl_t  mac_req;
    logic [32:0]         a_pick;
    logic [32:0]         b_pick;
    logic signed [sic_pkg::ACC_W-1:0] acc;
    logic [sic_pkg::STO_W-1:0]        done_store;

    logic signed [63:0] lin_val;
    logic [63:0]        lin_mag;
    logic [2:0]         lin_idx;

    // ------------------------------------------------------------------
    // register port: write on the access phase, reads are combinational
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[sic_pkg::PADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_row0_ab_reg     <= '0;
            f_row0c_row1a_reg <= '0;
            f_row1_bc_reg     <= '0;
            f_row2_ab_reg     <= '0;
            f_row2_c_reg      <= '0;
            thr_reg           <= sic_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                sic_pkg::REG_F_ROW0_AB:     f_row0_ab_reg     <= pwdata;
                sic_pkg::REG_F_ROW0C_ROW1A: f_row0c_row1a_reg <= pwdata;
                sic_pkg::REG_F_ROW1_BC:     f_row1_bc_reg     <= pwdata;
                sic_pkg::REG_F_ROW2_AB:     f_row2_ab_reg     <= pwdata;
                sic_pkg::REG_F_ROW2_C:      f_row2_c_reg      <= $signed(pwdata[31:0]);
                sic_pkg::REG_THRESHOLD:     thr_reg           <= pwdata[31:0];
                default:                    ; // unmapped offsets are ignored
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            sic_pkg::REG_F_ROW0_AB:     prdata = f_row0_ab_reg;
            sic_pkg::REG_F_ROW0C_ROW1A: prdata = f_row0c_row1a_reg;
            sic_pkg::REG_F_ROW1_BC:     prdata = f_row1_bc_reg;
            sic_pkg::REG_F_ROW2_AB:     prdata = f_row2_ab_reg;
            sic_pkg::REG_F_ROW2_C:      prdata = {32'd0, f_row2_c_reg};
            sic_pkg::REG_THRESHOLD:     prdata = {32'd0, thr_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    // a finished result moves to the output register once that slot is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_RUN;
                    step_next  = '0;
                end
            end
            S_RUN:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == sic_pkg::STEP_W'(sic_pkg::NUM_STEPS - 1))
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // last partial product has reached the accumulator
                if (done_store == sic_pkg::STO_FLAG)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x1_reg    <= first_x;
            y1_reg    <= first_y;
            x2_reg    <= second_x;
            y2_reg    <= second_y;
            start_reg <= start_of_set;
        end
    end

    // ------------------------------------------------------------------
    // operand selection: each source gives {sign, 32-bit magnitude}
    // ------------------------------------------------------------------
    function automatic logic [32:0] pick(input logic [sic_pkg::SRC_W-1:0] src);
        logic signed [31:0] sv;
        logic               use_sv;
        logic [32:0]        res;
        sv     = '0;
        use_sv = 1'b1;
        res    = '0;
        unique case (src)
            sic_pkg::SRC_F00: sv = $signed(f_row0_ab_reg[63:32]);
            sic_pkg::SRC_F01: sv = $signed(f_row0_ab_reg[31:0]);
            sic_pkg::SRC_F02: sv = $signed(f_row0c_row1a_reg[63:32]);
            sic_pkg::SRC_F10: sv = $signed(f_row0c_row1a_reg[31:0]);
            sic_pkg::SRC_F11: sv = $signed(f_row1_bc_reg[63:32]);
            sic_pkg::SRC_F12: sv = $signed(f_row1_bc_reg[31:0]);
            sic_pkg::SRC_F20: sv = $signed(f_row2_ab_reg[63:32]);
            sic_pkg::SRC_F21: sv = $signed(f_row2_ab_reg[31:0]);
            sic_pkg::SRC_F22: sv = f_row2_c_reg;
            sic_pkg::SRC_X1:  sv = x1_reg;
            sic_pkg::SRC_Y1:  sv = y1_reg;
            sic_pkg::SRC_X2:  sv = x2_reg;
            sic_pkg::SRC_Y2:  sv = y2_reg;
            sic_pkg::SRC_K16: sv = sic_pkg::K16;
            sic_pkg::SRC_A0L:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_A0], lin_mag_reg[LIN_A0][31:0]};
            end
            sic_pkg::SRC_A0H:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_A0], lin_mag_reg[LIN_A0][63:32]};
            end
            sic_pkg::SRC_A1L:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_A1], lin_mag_reg[LIN_A1][31:0]};
            end
            sic_pkg::SRC_A1H:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_A1], lin_mag_reg[LIN_A1][63:32]};
            end
            sic_pkg::SRC_A2L:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_A2], lin_mag_reg[LIN_A2][31:0]};
            end
            sic_pkg::SRC_A2H:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_A2], lin_mag_reg[LIN_A2][63:32]};
            end
            sic_pkg::SRC_B0L:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_B0], lin_mag_reg[LIN_B0][31:0]};
            end
            sic_pkg::SRC_B0H:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_B0], lin_mag_reg[LIN_B0][63:32]};
            end
            sic_pkg::SRC_B1L:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_B1], lin_mag_reg[LIN_B1][31:0]};
            end
            sic_pkg::SRC_B1H:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_B1], lin_mag_reg[LIN_B1][63:32]};
            end
            sic_pkg::SRC_RL:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_R], lin_mag_reg[LIN_R][31:0]};
            end
            sic_pkg::SRC_RH:
            begin
                use_sv = 1'b0;
                res = {lin_sgn_reg[LIN_R], lin_mag_reg[LIN_R][63:32]};
            end
            sic_pkg::SRC_DL:
            begin
                use_sv = 1'b0;
                res = {1'b0, den_reg[31:0]};
            end
            sic_pkg::SRC_DM:
            begin
                use_sv = 1'b0;
                res = {1'b0, den_reg[63:32]};
            end
            sic_pkg::SRC_DH:
            begin
                use_sv = 1'b0;
                res = {1'b0, den_reg[95:64]};
            end
            sic_pkg::SRC_THR:
            begin
                use_sv = 1'b0;
                res = {1'b0, thr_reg};
            end
            default:
            begin
                use_sv = 1'b0;
                res = '0;
            end
        endcase
        // -2^31 maps to magnitude 2^31, which still fits 32 unsigned bits
        if (use_sv)
            res = {sv[31], sv[31] ? 32'(-sv) : 32'(sv)};
        return res;
    endfunction

    always_comb
    begin
        uop    = sic_pkg::uop_at(step_reg);
        a_pick = pick(uop.a_src);
        b_pick = pick(uop.b_src);
        mac_req.vld   = (state_reg == S_RUN);
        mac_req.clr   = uop.clr;
        mac_req.sub   = a_pick[32] ^ b_pick[32] ^ uop.neg;
        mac_req.shift = uop.shift;
        mac_req.store = uop.store;
    end

    sic_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (mac_req),
        .a_mag      (a_pick[31:0]),
        .b_mag      (b_pick[31:0]),
        .acc        (acc),
        .done_store (done_store)
    );

    // ------------------------------------------------------------------
    // result latches: floor shift (19 for line terms, 16 for the residual)
    // then sign and magnitude for the later limb products
    // ------------------------------------------------------------------
    always_comb
    begin
        lin_val = (done_store == sic_pkg::STO_R) ? acc[79:16] : acc[82:19];
        lin_mag = lin_val[63] ? 64'(-lin_val) : 64'(lin_val);
        lin_idx = 3'(done_store - 4'd1);
        acc_pos = !acc[sic_pkg::ACC_W-1] && (|acc);
    end

    always_ff @(posedge clk)
    begin
        if (done_store == sic_pkg::STO_A0 || done_store == sic_pkg::STO_A1 ||
            done_store == sic_pkg::STO_A2 || done_store == sic_pkg::STO_B0 ||
            done_store == sic_pkg::STO_B1 || done_store == sic_pkg::STO_R)
        begin
            lin_sgn_reg[lin_idx] <= lin_val[63];
            lin_mag_reg[lin_idx] <= lin_mag;
        end
        if (done_store == sic_pkg::STO_DEN)
            den_reg <= acc[95:0];
        if (done_store == sic_pkg::STO_FLAG)
            hit_reg <= acc_pos;
    end

    // ------------------------------------------------------------------
    // running count and output register
    // ------------------------------------------------------------------
    always_comb
    begin
        count_base = start_reg ? '0 : count_reg;
        if (hit_reg && count_base != CNT_MAX)
            count_next = count_base + 1'b1;
        else
            count_next = count_base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_inlier_reg <= hit_reg;
            out_total_reg  <= sic_pkg::TOTAL_WIDTH'(count_next);
        end
    end

    assign out_valid    = out_valid_reg;
    assign is_inlier    = out_inlier_reg;
    assign inlier_total = out_total_reg;

endmodule

### rtl/core/sic_checker.sv
// Port-level checks for the Sampson inlier counter, bound to the top level.
// Depends on sic_pkg for the total width.
module sic_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            is_inlier,
    input logic [sic_pkg::TOTAL_WIDTH-1:0] inlier_total
);

    // a transaction keeps the block busy for many cycles
    a_busy_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after a transaction was taken");

    a_busy_later: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##3 !in_ready)
        else $error("in_ready returned before the program could finish");

    // the count includes the current point
    a_total_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_inlier |-> inlier_total != '0)
        else $error("inlier reported with a zero total");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_inlier) && $stable(inlier_total))
        else $error("stalled result changed or dropped");

endmodule

bind sampson_inlier_counter sic_checker u_sic_checker (.*);
